// File: rtl/rdcl_pkg.sv
// Shared constants for the radio duty cycle limiter and its checker.
`default_nettype none
package rdcl_pkg;

	// Field widths of the stream and configuration payloads
	localparam int REQ_TYPE_W   = 2;
	localparam int AIRTIME_W    = 16;
	localparam int CFG_TIME_W   = 22;
	localparam int DUTY_W       = 16;
	localparam int AIR_SUM_W    = 32;
	localparam int CFG_INDEX_W  = 2;
	localparam int S_TDATA_W    = 16;
	localparam int M_TDATA_W    = 40;
	localparam int M_TUSER_W    = 1;

	// Default width of the millisecond counters
	localparam int TIME_BITS_DEF = 22;

	// Request kinds carried on s_tuser
	localparam logic [REQ_TYPE_W-1:0] REQ_TICK = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_SEND = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_DONE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW       = 2'd2;

	// Register reset values
	localparam logic [CFG_TIME_W-1:0] MIN_INTERVAL_RST = 22'd36000;
	localparam logic [CFG_TIME_W-1:0] WINDOW_RST       = 22'd3600000;

	// Duty scale: hundredths of a percent
	localparam int                    SCALE_W    = 14;
	localparam logic [SCALE_W-1:0]    DUTY_SCALE = 14'd10000;
	localparam int                    PROD_W     = AIR_SUM_W + SCALE_W;

endpackage
`default_nettype wire

// File: rtl/radio_duty_cycle_limiter.sv
// Transmit pacing and airtime accounting with a bit-serial duty computation.
// Each item runs through a 14-step shift-add scaling multiply and a 16-step restoring
//   divider; the divider is skipped when the duty saturates or the window is empty.
// One item at a time: input is taken only between items, and a held result stalls
//   the sequencer and with it input and config.
// Reset (arst_n low, asynchronous): enabled 0, gap 36000 ms, window 3600000 ms, counters 0.
`default_nettype none
module radio_duty_cycle_limiter #(
	parameter int TIME_BITS = rdcl_pkg::TIME_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input stream
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [rdcl_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] airtime_ms
	input  wire logic [rdcl_pkg::REQ_TYPE_W-1:0]    s_tuser,   // [1:0] req_type
	// result stream
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [rdcl_pkg::M_TDATA_W-1:0]          m_tdata,   // [21:0] wait_ms,
	                                                           // [37:22] duty_hundredths,
	                                                           // [39:38] zero
	output logic [rdcl_pkg::M_TUSER_W-1:0]          m_tuser,   // [0] granted
	// configuration writes
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rdcl_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [rdcl_pkg::CFG_TIME_W-1:0]    cfg_data
);
	import rdcl_pkg::*;

	// Compare width wide enough for both the counters and the 22-bit registers
	localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
	localparam int HI_W  = PROD_W - DUTY_W;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;

	// Configuration registers
	logic                  enabled_q;
	logic [CFG_TIME_W-1:0] min_interval_q;
	logic [CFG_TIME_W-1:0] window_ms_q;

	// Pacing and accounting state
	logic [TIME_BITS-1:0]  since_send_q;
	logic                  has_sent_q;
	logic [TIME_BITS-1:0]  window_elapsed_q;
	logic [AIR_SUM_W-1:0]  window_airtime_q;

	// Per-item work registers
	logic                  grant_q;
	logic [CFG_TIME_W-1:0] wait_q;
	logic [CFG_TIME_W-1:0] w_q;         // min(window_elapsed, window_ms)
	logic [AIR_SUM_W-1:0]  air_q;       // multiplicand for the scaling multiply
	logic [PROD_W-1:0]     prod_q;      // airtime * 10000, built one scale bit a cycle
	logic [3:0]            mul_idx_q;   // scale bit being folded in, MSB first
	logic [CFG_TIME_W-1:0] rem_q;       // partial remainder, below w_q throughout the division
	logic [DUTY_W-1:0]     num_lo_q;    // numerator bits still to shift in
	logic [DUTY_W-1:0]     quo_q;       // quotient bits, LSB shifted in
	logic [3:0]            div_cnt_q;

	// Output register
	logic                  m_tvalid_q;
	logic                  granted_q;
	logic [CFG_TIME_W-1:0] wait_out_q;
	logic [DUTY_W-1:0]     duty_out_q;

	// Combinational helpers
	logic [CMP_W-1:0]      since_x;
	logic [CMP_W-1:0]      elapsed_x;
	logic [CMP_W-1:0]      min_x;
	logic [CMP_W-1:0]      window_x;
	logic                  wait_zero;
	logic [CFG_TIME_W-1:0] wait_now;
	logic [CFG_TIME_W-1:0] w_now;
	logic                  win_over;
	logic [AIR_SUM_W:0]    air_sum;
	logic [AIR_SUM_W-1:0]  air_base;
	logic [PROD_W-1:0]     prod_next;
	logic [HI_W-1:0]       prod_hi;
	logic [CFG_TIME_W:0]   trial;
	logic [CFG_TIME_W:0]   trial_diff;
	logic                  trial_ge;
	logic                  in_xfer;
	logic                  out_free;

	assign since_x   = CMP_W'(since_send_q);
	assign elapsed_x = CMP_W'(window_elapsed_q);
	assign min_x     = CMP_W'(min_interval_q);
	assign window_x  = CMP_W'(window_ms_q);

	// Remaining wait: nothing to wait for before the first send or once the
	// interval has run out; otherwise the difference fits the register width.
	assign wait_zero = !has_sent_q || (since_x >= min_x);
	assign wait_now  = wait_zero ? '0 : CFG_TIME_W'(min_x - since_x);

	assign w_now    = (elapsed_x < window_x) ? CFG_TIME_W'(elapsed_x) : window_ms_q;
	assign win_over = (elapsed_x >= window_x);

	// Saturating airtime accumulation, from a cleared window when it ran out
	assign air_base = win_over ? '0 : window_airtime_q;
	assign air_sum  = {1'b0, air_base} + (AIR_SUM_W + 1)'(s_tdata);

	// One shift-add step of the scaling multiply
	assign prod_next = {prod_q[PROD_W-2:0], 1'b0} +
	                   (DUTY_SCALE[mul_idx_q] ? PROD_W'(air_q) : '0);
	assign prod_hi   = prod_q[PROD_W-1:DUTY_W];

	// One restoring division step
	assign trial      = {rem_q, num_lo_q[DUTY_W-1]};
	assign trial_diff = trial - {1'b0, w_q};
	assign trial_ge   = (trial >= {1'b0, w_q});

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Accept input and configuration only between items; a configuration write
	// takes the cycle when both are offered at once
	assign s_tready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = granted_q;
	assign m_tdata   = {{(M_TDATA_W - CFG_TIME_W - DUTY_W){1'b0}}, duty_out_q, wait_out_q};

	// Configuration registers: written only while the block is idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= 1'b0;
			min_interval_q <= MIN_INTERVAL_RST;
			window_ms_q    <= WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENABLED:      enabled_q      <= cfg_data[0];
				CFG_MIN_INTERVAL: min_interval_q <= cfg_data;
				CFG_WINDOW:       window_ms_q    <= cfg_data;
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// Pacing and accounting state: applied at the input transfer itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_send_q     <= '0;
			has_sent_q       <= 1'b0;
			window_elapsed_q <= '0;
			window_airtime_q <= '0;
		end else if (in_xfer) begin
			unique case (s_tuser)
				REQ_TICK: begin
					// Saturating millisecond counters
					if (since_send_q != '1)
						since_send_q <= since_send_q + 1'b1;
					if (window_elapsed_q != '1)
						window_elapsed_q <= window_elapsed_q + 1'b1;
				end
				REQ_DONE: begin
					if (win_over)
						window_elapsed_q <= '0;
					window_airtime_q <= air_sum[AIR_SUM_W] ? '1 : air_sum[AIR_SUM_W-1:0];
					since_send_q     <= '0;
					has_sent_q       <= 1'b1;
				end
				default: ;  // a send request or the unused kind leaves state alone
			endcase
		end
	end

	// Sequencer for the per-item result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_xfer) state_q <= S_PREP;
				S_PREP: state_q <= S_MUL;
				S_MUL:  if (mul_idx_q == '0) state_q <= S_CHK;
				S_CHK: begin
					// An empty window or a quotient past 16 bits needs no division
					if (w_q == '0 || prod_hi >= HI_W'(w_q))
						state_q <= S_DONE;
					else
						state_q <= S_DIV;
				end
				S_DIV:  if (div_cnt_q == '0) state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result valid: raise when the output register loads, drop on its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Work datapath: payload registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				// A request sees unchanged state, so grant from the current wait
				if (in_xfer)
					grant_q <= (s_tuser == REQ_SEND) && enabled_q && wait_zero;
			end
			S_PREP: begin
				wait_q    <= wait_now;
				w_q       <= w_now;
				air_q     <= window_airtime_q;
				prod_q    <= '0;
				mul_idx_q <= 4'(SCALE_W - 1);
			end
			S_MUL: begin
				prod_q    <= prod_next;
				mul_idx_q <= mul_idx_q - 1'b1;
			end
			S_CHK: begin
				if (w_q == '0)
					quo_q <= '0;
				else if (prod_hi >= HI_W'(w_q))
					quo_q <= '1;
				rem_q     <= prod_q[DUTY_W +: CFG_TIME_W];
				num_lo_q  <= prod_q[DUTY_W-1:0];
				div_cnt_q <= 4'(DUTY_W - 1);
			end
			S_DIV: begin
				rem_q     <= trial_ge ? trial_diff[CFG_TIME_W-1:0] : trial[CFG_TIME_W-1:0];
				num_lo_q  <= {num_lo_q[DUTY_W-2:0], 1'b0};
				quo_q     <= {quo_q[DUTY_W-2:0], trial_ge};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					granted_q  <= grant_q;
					wait_out_q <= wait_q;
					duty_out_q <= quo_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/rdcl_checker.sv
// Port-level checker for the radio duty cycle limiter, bound to the top level.
`default_nettype none
module rdcl_assertions (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [rdcl_pkg::M_TDATA_W-1:0]   m_tdata,
	input wire logic [rdcl_pkg::M_TUSER_W-1:0]   m_tuser
);
	import rdcl_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A grant never comes with a pending wait
	a_grant_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[CFG_TIME_W-1:0] == '0)
		else $error("grant with nonzero wait");

	// One item at a time: input closes right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open during work");

	// A result follows an input transfer only after the work is done
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared right after transfer");

endmodule

bind radio_duty_cycle_limiter rdcl_assertions u_rdcl_assertions (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// File: verif/rdcl_checker.sv
`timescale 1ns / 1ps
// Stream checker for the radio duty cycle limiter: predicts each result and compares it.
module rdcl_checker
	import rdcl_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [S_TDATA_W-1:0]   s_tdata,   // [15:0] airtime_ms
	input  wire logic [REQ_TYPE_W-1:0]  s_tuser,   // [1:0] req_type
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [M_TDATA_W-1:0]   m_tdata,   // [21:0] wait_ms, [37:22] duty_hundredths
	input  wire logic [M_TUSER_W-1:0]   m_tuser,   // [0] granted
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_TIME_W-1:0]  cfg_data,
	output int                          mismatches,
	output int                          outstanding,
	output int                          results_seen,
	output int                          grants_seen
);

	typedef struct packed {
		logic                  granted;
		logic [CFG_TIME_W-1:0] wait_ms;
		logic [DUTY_W-1:0]     duty;
	} tx_status_t;

	localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;
	localparam logic [AIR_SUM_W-1:0] AIR_SUM_MAX = '1;

	// Shadow registers and pacing state
	logic                  tx_enabled    = 1'b0;
	logic [CFG_TIME_W-1:0] min_gap_ms    = MIN_INTERVAL_RST;
	logic [CFG_TIME_W-1:0] window_len_ms = WINDOW_RST;
	logic [TIME_BITS-1:0]  since_done    = '0;
	logic                  done_seen     = 1'b0;
	logic [TIME_BITS-1:0]  window_age    = '0;
	logic [AIR_SUM_W-1:0]  window_air    = '0;

	tx_status_t status_q[$];
	int fail_cnt   = 0;
	int result_cnt = 0;
	int grant_cnt  = 0;

	function automatic logic [CFG_TIME_W-1:0] wait_remaining();
		if (!done_seen || 64'(since_done) >= 64'(min_gap_ms))
			return '0;
		return CFG_TIME_W'(64'(min_gap_ms) - 64'(since_done));
	endfunction

	// Airtime share of the elapsed window in hundredths of a percent
	function automatic logic [DUTY_W-1:0] duty_level();
		logic [63:0] span;
		logic [63:0] ratio;
		span = (64'(window_age) < 64'(window_len_ms)) ? 64'(window_age) : 64'(window_len_ms);
		if (span == 0)
			return '0;
		ratio = 64'(window_air) * 64'(DUTY_SCALE) / span;
		return (ratio > 64'(16'hFFFF)) ? '1 : ratio[DUTY_W-1:0];
	endfunction

	task automatic take_item(input logic [REQ_TYPE_W-1:0] kind,
			input logic [AIRTIME_W-1:0] air);
		tx_status_t           want;
		logic [AIR_SUM_W:0]   sum;
		want = '0;
		case (kind)
			REQ_TICK: begin
				if (since_done != TIME_MAX)
					since_done = since_done + 1'b1;
				if (window_age != TIME_MAX)
					window_age = window_age + 1'b1;
			end
			REQ_SEND: want.granted = tx_enabled && (wait_remaining() == '0);
			REQ_DONE: begin
				// restart an expired window before adding
				if (64'(window_age) >= 64'(window_len_ms)) begin
					window_air = '0;
					window_age = '0;
				end
				sum = {1'b0, window_air} + (AIR_SUM_W + 1)'(air);
				window_air = sum[AIR_SUM_W] ? AIR_SUM_MAX : sum[AIR_SUM_W-1:0];
				since_done = '0;
				done_seen  = 1'b1;
			end
			default: ;
		endcase
		want.wait_ms = wait_remaining();
		want.duty    = duty_level();
		status_q.push_back(want);
	endtask

	task automatic check_result(input tx_status_t seen);
		tx_status_t want;
		result_cnt++;
		if (seen.granted)
			grant_cnt++;
		if (status_q.size() == 0) begin
			$display("%0t: unexpected result: granted %0d wait_ms %0d duty %0d",
				$time, seen.granted, seen.wait_ms, seen.duty);
			fail_cnt++;
			return;
		end
		want = status_q.pop_front();
		if (seen.granted !== want.granted) begin
			$display("%0t: granted expected %0d, got %0d", $time, want.granted, seen.granted);
			fail_cnt++;
		end
		if (seen.wait_ms !== want.wait_ms) begin
			$display("%0t: wait_ms expected %0d, got %0d", $time, want.wait_ms, seen.wait_ms);
			fail_cnt++;
		end
		if (seen.duty !== want.duty) begin
			$display("%0t: duty_hundredths expected %0d, got %0d", $time, want.duty, seen.duty);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_enabled    = 1'b0;
			min_gap_ms    = MIN_INTERVAL_RST;
			window_len_ms = WINDOW_RST;
			since_done    = '0;
			done_seen     = 1'b0;
			window_age    = '0;
			window_air    = '0;
			status_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ENABLED:      tx_enabled    = cfg_data[0];
					CFG_MIN_INTERVAL: min_gap_ms    = cfg_data;
					CFG_WINDOW:       window_len_ms = cfg_data;
					default: ;
				endcase
			end
			// drain before predicting: a result never leaves in its own input cycle
			if (m_tvalid && m_tready)
				check_result({m_tuser[0], m_tdata[CFG_TIME_W-1:0], m_tdata[CFG_TIME_W +: DUTY_W]});
			if (s_tvalid && s_tready)
				take_item(s_tuser, s_tdata[AIRTIME_W-1:0]);
		end
		mismatches   <= fail_cnt;
		outstanding  <= status_q.size();
		results_seen <= result_cnt;
		grants_seen  <= grant_cnt;
	end

endmodule

// File: verif/tb_radio_duty_cycle_limiter.sv
`timescale 1ns / 1ps
// Top-level testbench for the radio duty cycle limiter: stimulus, pacing and verdict.
module tb_radio_duty_cycle_limiter
	import rdcl_pkg::*;
;

	// Spare request code: the block must answer it without touching state
	localparam logic [REQ_TYPE_W-1:0] REQ_SPARE = 2'd3;

	localparam int LONG_HOLD    = 400;  // cycles the receiver refuses results once
	localparam int DRAIN_CYCLES = 40;   // idle cycles after the last result before the next step
	localparam int N_PHASES     = 9;
	localparam int PHASE_ITEMS  = 55;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;    // [15:0] airtime_ms
	logic [REQ_TYPE_W-1:0]  s_tuser   = '0;    // [1:0] req_type
	logic                   m_tready  = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_TIME_W-1:0]  cfg_data  = '0;

	wire logic                 s_tready;
	wire logic                 m_tvalid;
	wire logic [M_TDATA_W-1:0] m_tdata;    // [21:0] wait_ms, [37:22] duty_hundredths
	wire logic [M_TUSER_W-1:0] m_tuser;    // [0] granted
	wire logic                 cfg_ready;

	int mismatches;
	int outstanding;
	int results_seen;
	int grants_seen;

	// Pacing knobs: percent of cycles each side idles
	int src_idle_pct = 17;
	int snk_idle_pct = 74;

	// Long receiver hold: the stimulus asks, the receiver process counts it out
	int holds_asked   = 0;
	int holds_granted = 0;
	int hold_left     = 0;

	int items_sent = 0;
	int settings   = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	radio_duty_cycle_limiter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rdcl_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.grants_seen  (grants_seen)
	);

	// Receiver: random back-pressure, or a long hold when the stimulus asks for one.
	// While held, the block keeps accepting until its result register is full and a
	// further result waits in the sequencer, then it has to stall its input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_granted != holds_asked) begin
			m_tready      <= 1'b0;
			hold_left     <= LONG_HOLD;
			holds_granted <= holds_granted + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("tb_radio_duty_cycle_limiter: FAIL");
		$finish;
	end

	// Airtime: mostly realistic values, a quarter spread over the whole field
	function automatic logic [AIRTIME_W-1:0] pick_air();
		if ($urandom_range(3) == 0)
			return AIRTIME_W'($urandom);
		return AIRTIME_W'($urandom_range(300));
	endfunction

	// Offer one item and hold it until the transfer. The valid stays high on
	// return so that back-to-back items never lower and raise it in one step.
	task automatic push_item(input logic [REQ_TYPE_W-1:0] kind,
			input logic [AIRTIME_W-1:0] air);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= air;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_TIME_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Write all three registers; the unused upper bits of enabled carry noise
	task automatic configure(input logic en, input logic [CFG_TIME_W-1:0] min_gap,
			input logic [CFG_TIME_W-1:0] win);
		write_reg(CFG_ENABLED, {21'($urandom), en});
		write_reg(CFG_MIN_INTERVAL, min_gap);
		write_reg(CFG_WINDOW, win);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Mostly well-formed send cycles (wait out the gap with ticks, request,
	// report completion), with single stray items mixed in as noise.
	task automatic run_traffic(input int n_items, input logic [CFG_TIME_W-1:0] min_gap);
		int first;
		int roll;
		int tick_cap;
		first    = items_sent;
		tick_cap = (min_gap < 37) ? int'(min_gap) + 3 : 40;
		while (items_sent - first < n_items) begin
			roll = $urandom_range(99);
			if (roll < 70) begin
				repeat ($urandom_range(tick_cap)) push_item(REQ_TICK, pick_air());
				push_item(REQ_SEND, pick_air());
				push_item(REQ_DONE, pick_air());
			end else if (roll < 80) begin
				push_item(REQ_SEND, pick_air());
			end else if (roll < 88) begin
				push_item(REQ_DONE, pick_air());
			end else if (roll < 96) begin
				push_item(REQ_TICK, pick_air());
			end else begin
				push_item(REQ_SPARE, pick_air());
			end
		end
	endtask

	initial begin
		logic                  en;
		logic [CFG_TIME_W-1:0] min_gap;
		logic [CFG_TIME_W-1:0] win;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: disabled, long gap and window.
		// A request before any send reports no wait but is refused.
		push_item(REQ_SEND, 16'h0000);
		push_item(REQ_TICK, 16'h0000);
		// full airtime over a one-tick window saturates the duty
		push_item(REQ_DONE, 16'hFFFF);
		// refused while disabled, yet the wait is still shown
		push_item(REQ_SEND, 16'h0000);
		push_item(REQ_SPARE, 16'hAAAA);
		push_item(REQ_TICK, 16'h5555);
		push_item(REQ_DONE, 16'h0000);
		settle();

		// Enabled, no minimum gap, one-tick window: every completion restarts
		configure(1'b1, '0, 22'd1);
		push_item(REQ_SEND, 16'h0000);
		push_item(REQ_TICK, 16'h0000);
		push_item(REQ_DONE, 16'h5555);
		push_item(REQ_TICK, 16'h0000);
		push_item(REQ_DONE, 16'h0001);
		push_item(REQ_SEND, 16'h0000);
		settle();

		// Zero window: duty stays zero and every completion restarts the window
		configure(1'b1, '0, '0);
		push_item(REQ_DONE, 16'd100);
		push_item(REQ_TICK, 16'h0000);
		push_item(REQ_SEND, 16'h0000);
		settle();

		// Largest gap and window
		configure(1'b1, '1, '1);
		push_item(REQ_SEND, 16'hFFFF);
		push_item(REQ_TICK, 16'h0000);
		push_item(REQ_SEND, 16'h0000);
		push_item(REQ_DONE, 16'hFFFF);
		push_item(REQ_TICK, 16'h0000);
		push_item(REQ_SPARE, 16'h0000);
		settle();

		// Random phases, three per pacing mode
		for (int p = 0; p < N_PHASES; p++) begin
			case (p / 3)
				0: begin
					src_idle_pct = 17;
					snk_idle_pct <= 74;
				end
				1: begin
					src_idle_pct = 74;
					snk_idle_pct <= 17;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct <= 0;
				end
			endcase

			en      = (p != 4);
			min_gap = (p == 1) ? '0 :
				(p == 2) ? CFG_TIME_W'($urandom) : CFG_TIME_W'($urandom_range(1, 30));
			win     = (p == 3) ? '0 : (p == 5) ? '1 :
				(p == 7) ? CFG_TIME_W'($urandom) : CFG_TIME_W'($urandom_range(1, 80));
			configure(en, min_gap, win);

			if (p == 1) begin
				// hold the result side off while items keep coming
				holds_asked <= holds_asked + 1;
				run_traffic(PHASE_ITEMS, min_gap);
			end else if (p == 6) begin
				// pause the sender midway until the block has answered everything
				run_traffic(PHASE_ITEMS / 2, min_gap);
				settle();
				run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2, min_gap);
			end else begin
				run_traffic(PHASE_ITEMS, min_gap);
			end
			settle();
		end

		$display("Run covered %0d requests and %0d results (%0d granted) under %0d register settings,",
			items_sent, results_seen, grants_seen, settings);
		$display("with zero and full-scale gap and window, disabled phases and long back-pressure.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_radio_duty_cycle_limiter: PASS");
		end else begin
			$display("tb_radio_duty_cycle_limiter: FAIL");
		end
		$finish;
	end

endmodule

// File: radio_duty_cycle_limiter.f
rtl/rdcl_pkg.sv
rtl/radio_duty_cycle_limiter.sv
rtl/rdcl_checker.sv
verif/rdcl_checker.sv
verif/tb_radio_duty_cycle_limiter.sv
